// ===== src/ect_pkg.sv =====
package ect_pkg;

	localparam int MAX_VERTS_DEF  = 64;
	localparam int COORD_BITS_DEF = 32;

	// Result status codes.
	localparam logic [1:0] STATUS_TRI      = 2'd0;
	localparam logic [1:0] STATUS_FAILED   = 2'd1;
	localparam logic [1:0] STATUS_EMPTY    = 2'd2;
	localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

	// Micro-operations of the shared arithmetic engine.
	typedef enum logic [2:0] {
		UOP_LDX,
		UOP_LDY,
		UOP_ADD,
		UOP_SUB,
		UOP_MUL,
		UOP_END
	} uop_code_t;

	// For loads, sa holds the vertex slot (0..3).
	typedef struct packed {
		uop_code_t  op;
		logic [3:0] dst;
		logic [3:0] sa;
		logic [3:0] sb;
	} uop_t;

	localparam int UCODE_LEN  = 52;
	localparam int UPC_W      = 6;
	localparam int RF_DEPTH   = 16;

	// Program entry points.
	localparam logic [UPC_W-1:0] PC_ORIENT   = 6'd0;
	localparam logic [UPC_W-1:0] PC_INCIRCLE = 6'd14;

	localparam uop_t UCODE [UCODE_LEN] = '{
		// Orientation of slots 0, 1, 2.
		'{UOP_LDX, 4'd0,  4'd0,  4'd0},
		'{UOP_LDY, 4'd1,  4'd0,  4'd0},
		'{UOP_LDX, 4'd2,  4'd1,  4'd0},
		'{UOP_SUB, 4'd2,  4'd2,  4'd0},
		'{UOP_LDY, 4'd3,  4'd1,  4'd0},
		'{UOP_SUB, 4'd3,  4'd3,  4'd1},
		'{UOP_LDX, 4'd4,  4'd2,  4'd0},
		'{UOP_SUB, 4'd4,  4'd4,  4'd0},
		'{UOP_LDY, 4'd5,  4'd2,  4'd0},
		'{UOP_SUB, 4'd5,  4'd5,  4'd1},
		'{UOP_MUL, 4'd2,  4'd2,  4'd5},
		'{UOP_MUL, 4'd3,  4'd3,  4'd4},
		'{UOP_SUB, 4'd2,  4'd2,  4'd3},
		'{UOP_END, 4'd0,  4'd0,  4'd0},
		// Incircle determinant of slot 3 against slots 0, 1, 2.
		'{UOP_LDX, 4'd0,  4'd3,  4'd0},
		'{UOP_LDY, 4'd1,  4'd3,  4'd0},
		'{UOP_LDX, 4'd2,  4'd0,  4'd0},
		'{UOP_SUB, 4'd2,  4'd2,  4'd0},
		'{UOP_LDY, 4'd3,  4'd0,  4'd0},
		'{UOP_SUB, 4'd3,  4'd3,  4'd1},
		'{UOP_LDX, 4'd4,  4'd1,  4'd0},
		'{UOP_SUB, 4'd4,  4'd4,  4'd0},
		'{UOP_LDY, 4'd5,  4'd1,  4'd0},
		'{UOP_SUB, 4'd5,  4'd5,  4'd1},
		'{UOP_LDX, 4'd6,  4'd2,  4'd0},
		'{UOP_SUB, 4'd6,  4'd6,  4'd0},
		'{UOP_LDY, 4'd7,  4'd2,  4'd0},
		'{UOP_SUB, 4'd7,  4'd7,  4'd1},
		'{UOP_MUL, 4'd8,  4'd2,  4'd2},
		'{UOP_MUL, 4'd9,  4'd3,  4'd3},
		'{UOP_ADD, 4'd8,  4'd8,  4'd9},
		'{UOP_MUL, 4'd9,  4'd4,  4'd4},
		'{UOP_MUL, 4'd10, 4'd5,  4'd5},
		'{UOP_ADD, 4'd9,  4'd9,  4'd10},
		'{UOP_MUL, 4'd10, 4'd6,  4'd6},
		'{UOP_MUL, 4'd11, 4'd7,  4'd7},
		'{UOP_ADD, 4'd10, 4'd10, 4'd11},
		'{UOP_MUL, 4'd11, 4'd10, 4'd5},
		'{UOP_MUL, 4'd12, 4'd9,  4'd7},
		'{UOP_SUB, 4'd11, 4'd11, 4'd12},
		'{UOP_MUL, 4'd11, 4'd11, 4'd2},
		'{UOP_MUL, 4'd12, 4'd10, 4'd4},
		'{UOP_MUL, 4'd13, 4'd9,  4'd6},
		'{UOP_SUB, 4'd12, 4'd12, 4'd13},
		'{UOP_MUL, 4'd12, 4'd12, 4'd3},
		'{UOP_MUL, 4'd13, 4'd4,  4'd7},
		'{UOP_MUL, 4'd14, 4'd6,  4'd5},
		'{UOP_SUB, 4'd13, 4'd13, 4'd14},
		'{UOP_MUL, 4'd13, 4'd13, 4'd8},
		'{UOP_SUB, 4'd11, 4'd11, 4'd12},
		'{UOP_ADD, 4'd11, 4'd11, 4'd13},
		'{UOP_END, 4'd0,  4'd0,  4'd0}
	};

	typedef struct packed {
		logic             start;
		logic [UPC_W-1:0] entry;
	} eng_cmd_t;

	typedef struct packed {
		logic done;
		logic neg;
		logic zero;
	} eng_stat_t;

endpackage

// ===== src/ect_vtx_if.sv =====
interface ect_vtx_if #(
	parameter int COORD_BITS = ect_pkg::COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] vertex_x;
	logic signed [COORD_BITS-1:0] vertex_y;
	logic [31:0]                  index_base;
	logic                         last_vertex;

	modport source(output valid, vertex_x, vertex_y, index_base, last_vertex, input ready);
	modport sink(input valid, vertex_x, vertex_y, index_base, last_vertex, output ready);
endinterface

// ===== src/ect_tri_if.sv =====
interface ect_tri_if;
	logic        valid;
	logic        ready;
	logic [31:0] corner_a;
	logic [31:0] corner_b;
	logic [31:0] corner_c;
	logic [1:0]  status;
	logic        end_of_run;

	modport source(output valid, corner_a, corner_b, corner_c, status, end_of_run,
		input ready);
	modport sink(input valid, corner_a, corner_b, corner_c, status, end_of_run,
		output ready);
endinterface

// ===== src/ect_engine.sv =====
// Microcoded exact-arithmetic engine: a register file, one wide adder and a
// shift-and-add multiplier that stops once the remaining multiplier bits are
// all sign bits.
module ect_engine #(
	parameter int COORD_BITS = ect_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ect_pkg::eng_cmd_t            cmd,
	output logic [1:0]                   ld_slot,
	input  logic signed [COORD_BITS-1:0] x_coord,
	input  logic signed [COORD_BITS-1:0] y_coord,
	output ect_pkg::eng_stat_t           stat
);
	localparam int BW = 4 * COORD_BITS + 10;

	typedef enum logic [1:0] {E_IDLE, E_FETCH, E_EXEC, E_MUL} estate_t;

	estate_t                    st_q;
	logic [ect_pkg::UPC_W-1:0]  pc_q;
	ect_pkg::uop_t              uop;
	logic [BW-1:0]              rf [ect_pkg::RF_DEPTH];
	logic [BW-1:0]              rda_q, rdb_q;
	logic [BW-1:0]              acc_q, mcand_q, mplier_q;
	logic                       done_q, neg_q, zero_q;

	logic [BW-1:0] add_x, add_y, sum;
	logic          add_sub;
	logic          mul_end;
	logic          wr_en;
	logic [BW-1:0] wr_data;
	logic [BW-1:0] ld_val;

	assign uop     = ect_pkg::UCODE[pc_q];
	assign ld_slot = uop.sa[1:0];
	assign stat    = '{done: done_q, neg: neg_q, zero: zero_q};

	assign mul_end = (mplier_q == '0) || (mplier_q == '1);

	always_comb begin
		add_x   = rda_q;
		add_y   = rdb_q;
		add_sub = (uop.op == ect_pkg::UOP_SUB);
		if (st_q == E_MUL) begin
			add_x   = acc_q;
			add_y   = mplier_q[0] ? mcand_q : '0;
			add_sub = (mplier_q == '1);
		end
		sum = add_x + (add_y ^ {BW{add_sub}}) + BW'(add_sub);
	end

	always_comb begin
		if (uop.op == ect_pkg::UOP_LDX) begin
			ld_val = {{(BW - COORD_BITS){x_coord[COORD_BITS-1]}}, x_coord};
		end else begin
			ld_val = {{(BW - COORD_BITS){y_coord[COORD_BITS-1]}}, y_coord};
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_data = sum;
		if (st_q == E_EXEC) begin
			case (uop.op) inside
				ect_pkg::UOP_LDX, ect_pkg::UOP_LDY: begin
					wr_en   = 1'b1;
					wr_data = ld_val;
				end
				ect_pkg::UOP_ADD, ect_pkg::UOP_SUB: wr_en = 1'b1;
				default: wr_en = 1'b0;
			endcase
		end else if (st_q == E_MUL) begin
			wr_en = mul_end;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			rf[uop.dst] <= wr_data;
		end
		rda_q <= rf[uop.sa];
		rdb_q <= rf[uop.sb];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= E_IDLE;
			pc_q     <= '0;
			done_q   <= 1'b0;
			neg_q    <= 1'b0;
			zero_q   <= 1'b0;
			acc_q    <= '0;
			mcand_q  <= '0;
			mplier_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (wr_en) begin
				neg_q  <= wr_data[BW-1];
				zero_q <= (wr_data == '0);
			end
			unique case (st_q)
				E_IDLE: begin
					if (cmd.start) begin
						pc_q <= cmd.entry;
						st_q <= E_FETCH;
					end
				end
				E_FETCH: st_q <= E_EXEC;
				E_EXEC: begin
					unique case (uop.op)
						ect_pkg::UOP_MUL: begin
							acc_q    <= '0;
							mcand_q  <= rda_q;
							mplier_q <= rdb_q;
							st_q     <= E_MUL;
						end
						ect_pkg::UOP_END: begin
							done_q <= 1'b1;
							st_q   <= E_IDLE;
						end
						default: begin
							pc_q <= pc_q + 1'b1;
							st_q <= E_FETCH;
						end
					endcase
				end
				E_MUL: begin
					if (mul_end) begin
						pc_q <= pc_q + 1'b1;
						st_q <= E_FETCH;
					end else begin
						acc_q    <= sum;
						mcand_q  <= {mcand_q[BW-2:0], 1'b0};
						mplier_q <= {mplier_q[BW-1], mplier_q[BW-1:1]};
					end
				end
				default: st_q <= E_IDLE;
			endcase
		end
	end
endmodule

// ===== src/ear_clip_triangulator.sv =====
// Ear-clipping triangulator. Vertices arrive one per transfer on verts,
// the last one marked; index_base is taken from the polygon's
// first vertex. After the marked vertex the block stops taking vertices and
// triangulates: it walks the ring of active vertices, and clips a strictly
// convex vertex whose circumcircle holds no other active vertex, or, after
// a lap with no such ear, the first plain ear found in that lap. Each
// triangle comes out as one transfer on tris (previous, tip, next corner,
// base added), the last one flagged by end_of_run; a polygon with fewer
// than three vertices, more than MAX_VERTS vertices, or no ear at all gives
// a single transfer with status empty, overflow or failed. All geometry is
// exact integer arithmetic done by one shared microcoded engine with a
// 4*COORD_BITS+10 bit adder and a one-bit-per-cycle multiplier. An
// orientation test uses two multiplies and an incircle test fifteen. A
// polygon of N vertices runs on the order of N*N such tests per clip, so
// triangulation time grows as N cubed, and the output is then drained one
// triangle at a time: each is read from the triangle store, captured and
// held on tris until it is taken, before the next one is read.
module ear_clip_triangulator #(
	parameter int MAX_VERTS  = ect_pkg::MAX_VERTS_DEF,
	parameter int COORD_BITS = ect_pkg::COORD_BITS_DEF
) (
	input logic      clk,
	input logic      arst_n,
	ect_vtx_if.sink  verts,
	ect_tri_if.source tris
);
	localparam int PW = $clog2(MAX_VERTS);
	localparam int CW = $clog2(MAX_VERTS + 2);

	typedef enum logic [4:0] {
		S_LOAD, S_FILL, S_TOP, S_RD0, S_RD1, S_RD2, S_RD3, S_CONVEX,
		S_SCAN, S_SCAN_P, S_CIRC, S_TRI, S_ADV, S_CLIP_W, S_MV_RD,
		S_MV_WR, S_CLIP_END, S_EMIT_RD, S_EMIT_CAP, S_EMIT_WAIT
	} state_t;

	// Which vertices the engine's slots 0..2 refer to; slot 3 is always p.
	typedef enum logic [1:0] {M_ABC, M_T1, M_T2, M_T3} mode_t;

	state_t state_q;
	mode_t  mode_q;

	logic [CW-1:0] vc_q, size_q;
	logic [PW-1:0] fill_q, cur_q, lap_q, fb_pos_q, kk_q, pk_q, nk_q, j_q;
	logic [PW-1:0] tri_cnt_q, e_idx_q;
	logic [PW-1:0] va_q, vb_q, vc_vid_q, vp_q;
	logic          fb_found_q, trad_q, circ_q, rd_clip_q, last_tri_q;
	logic [1:0]    it_q, sg1_q, sg2_q;
	logic [31:0]   base_q;

	logic [31:0] out_a_q, out_b_q, out_c_q;
	logic [1:0]  out_st_q;
	logic        out_eor_q, out_valid_q;

	// Vertex coordinate, ring and triangle stores.
	logic [COORD_BITS-1:0] xmem [MAX_VERTS];
	logic [COORD_BITS-1:0] ymem [MAX_VERTS];
	logic [PW-1:0]         ring [MAX_VERTS];
	logic [3*PW-1:0]       tmem [MAX_VERTS];
	logic [COORD_BITS-1:0] x_rd_q, y_rd_q;
	logic [PW-1:0]         ring_rd_q;
	logic [3*PW-1:0]       tmem_rd_q;

	ect_pkg::eng_cmd_t  cmd_q;
	ect_pkg::eng_stat_t stat;
	logic [1:0]         ld_slot;

	logic          in_acc, out_acc;
	logic [CW-1:0] nvc;
	logic [PW-1:0] coord_addr, ring_ra, ring_wa, ring_wd;
	logic          ring_we, tmem_we;
	logic [1:0]    sgn;

	function automatic logic [PW-1:0] ring_next(logic [PW-1:0] k, logic [CW-1:0] sz);
		return (CW'(k) + 1'b1 >= sz) ? '0 : k + 1'b1;
	endfunction

	function automatic logic [PW-1:0] ring_prev(logic [PW-1:0] k, logic [CW-1:0] sz);
		logic [CW-1:0] last;
		last = sz - 1'b1;
		return (k == '0) ? last[PW-1:0] : k - 1'b1;
	endfunction

	assign in_acc      = verts.valid && verts.ready;
	assign out_acc     = tris.valid && tris.ready;
	assign verts.ready = (state_q == S_LOAD) && !out_valid_q;

	assign tris.valid      = out_valid_q;
	assign tris.corner_a   = out_a_q;
	assign tris.corner_b   = out_b_q;
	assign tris.corner_c   = out_c_q;
	assign tris.status     = out_st_q;
	assign tris.end_of_run = out_eor_q;

	assign nvc = (vc_q < CW'(MAX_VERTS)) ? vc_q + 1'b1 : CW'(MAX_VERTS + 1);
	assign sgn = {stat.neg, stat.zero};

	// Vertex behind each engine slot under the current test.
	always_comb begin
		coord_addr = vp_q;
		unique case (mode_q)
			M_ABC: begin
				case (ld_slot)
					2'd0: coord_addr = va_q;
					2'd1: coord_addr = vb_q;
					2'd2: coord_addr = vc_vid_q;
					default: coord_addr = vp_q;
				endcase
			end
			M_T1: begin
				case (ld_slot)
					2'd1: coord_addr = va_q;
					2'd2: coord_addr = vb_q;
					default: coord_addr = vp_q;
				endcase
			end
			M_T2: begin
				case (ld_slot)
					2'd1: coord_addr = vb_q;
					2'd2: coord_addr = vc_vid_q;
					default: coord_addr = vp_q;
				endcase
			end
			M_T3: begin
				case (ld_slot)
					2'd1: coord_addr = vc_vid_q;
					2'd2: coord_addr = va_q;
					default: coord_addr = vp_q;
				endcase
			end
			default: coord_addr = vp_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_acc && (vc_q < CW'(MAX_VERTS))) begin
			xmem[vc_q[PW-1:0]] <= verts.vertex_x;
			ymem[vc_q[PW-1:0]] <= verts.vertex_y;
		end
		x_rd_q <= xmem[coord_addr];
		y_rd_q <= ymem[coord_addr];
	end

	// Ring and triangle store port control.
	always_comb begin
		ring_ra = '0;
		case (state_q)
			S_RD0:   ring_ra = ring_prev(kk_q, size_q);
			S_RD1:   ring_ra = kk_q;
			S_RD2:   ring_ra = ring_next(kk_q, size_q);
			S_SCAN:  ring_ra = j_q;
			S_MV_RD: ring_ra = j_q + 1'b1;
			default: ring_ra = '0;
		endcase
		ring_we = (state_q == S_FILL) || (state_q == S_MV_WR);
		ring_wa = (state_q == S_FILL) ? fill_q : j_q;
		ring_wd = (state_q == S_FILL) ? fill_q : ring_rd_q;
		tmem_we = (state_q == S_CLIP_W);
	end

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring[ring_wa] <= ring_wd;
		end
		ring_rd_q <= ring[ring_ra];
		if (tmem_we) begin
			tmem[tri_cnt_q] <= {va_q, vb_q, vc_vid_q};
		end
		tmem_rd_q <= tmem[e_idx_q];
	end

	ect_engine #(
		.COORD_BITS(COORD_BITS)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_q),
		.ld_slot (ld_slot),
		.x_coord (x_rd_q),
		.y_coord (y_rd_q),
		.stat    (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			mode_q      <= M_ABC;
			vc_q        <= '0;
			size_q      <= '0;
			fill_q      <= '0;
			cur_q       <= '0;
			lap_q       <= '0;
			fb_pos_q    <= '0;
			fb_found_q  <= 1'b0;
			kk_q        <= '0;
			pk_q        <= '0;
			nk_q        <= '0;
			j_q         <= '0;
			tri_cnt_q   <= '0;
			e_idx_q     <= '0;
			va_q        <= '0;
			vb_q        <= '0;
			vc_vid_q    <= '0;
			vp_q        <= '0;
			trad_q      <= 1'b0;
			circ_q      <= 1'b0;
			rd_clip_q   <= 1'b0;
			last_tri_q  <= 1'b0;
			it_q        <= '0;
			sg1_q       <= '0;
			sg2_q       <= '0;
			base_q      <= '0;
			cmd_q       <= '0;
			out_a_q     <= '0;
			out_b_q     <= '0;
			out_c_q     <= '0;
			out_st_q    <= ect_pkg::STATUS_TRI;
			out_eor_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_acc) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						if (vc_q == '0) begin
							base_q <= verts.index_base;
						end
						if (verts.last_vertex) begin
							vc_q <= '0;
							if (nvc > CW'(MAX_VERTS)) begin
								out_a_q     <= '0;
								out_b_q     <= '0;
								out_c_q     <= '0;
								out_st_q    <= ect_pkg::STATUS_OVERFLOW;
								out_eor_q   <= 1'b1;
								out_valid_q <= 1'b1;
							end else if (nvc < CW'(3)) begin
								out_a_q     <= '0;
								out_b_q     <= '0;
								out_c_q     <= '0;
								out_st_q    <= ect_pkg::STATUS_EMPTY;
								out_eor_q   <= 1'b1;
								out_valid_q <= 1'b1;
							end else begin
								size_q  <= nvc;
								fill_q  <= '0;
								state_q <= S_FILL;
							end
						end else begin
							vc_q <= nvc;
						end
					end
				end
				S_FILL: begin
					fill_q <= fill_q + 1'b1;
					if (CW'(fill_q) == size_q - 1'b1) begin
						cur_q      <= '0;
						lap_q      <= '0;
						fb_pos_q   <= '0;
						fb_found_q <= 1'b0;
						tri_cnt_q  <= '0;
						last_tri_q <= 1'b0;
						state_q    <= S_TOP;
					end
				end
				S_TOP: begin
					if (size_q > CW'(3)) begin
						kk_q      <= cur_q;
						rd_clip_q <= 1'b0;
					end else begin
						// Three vertices left: they form the closing triangle.
						kk_q       <= PW'(1);
						last_tri_q <= 1'b1;
						rd_clip_q  <= 1'b1;
					end
					state_q <= S_RD0;
				end
				S_RD0: begin
					pk_q    <= ring_prev(kk_q, size_q);
					nk_q    <= ring_next(kk_q, size_q);
					state_q <= S_RD1;
				end
				S_RD1: begin
					va_q    <= ring_rd_q;
					state_q <= S_RD2;
				end
				S_RD2: begin
					vb_q    <= ring_rd_q;
					state_q <= S_RD3;
				end
				S_RD3: begin
					vc_vid_q <= ring_rd_q;
					if (rd_clip_q) begin
						state_q <= S_CLIP_W;
					end else begin
						mode_q  <= M_ABC;
						cmd_q   <= '{start: 1'b1, entry: ect_pkg::PC_ORIENT};
						state_q <= S_CONVEX;
					end
				end
				S_CONVEX: begin
					if (stat.done) begin
						if (!stat.neg && !stat.zero) begin
							trad_q  <= fb_found_q;
							circ_q  <= 1'b1;
							j_q     <= ring_next(nk_q, size_q);
							state_q <= S_SCAN;
						end else begin
							state_q <= S_ADV;
						end
					end else begin
						cmd_q.start <= 1'b0;
					end
				end
				S_SCAN: begin
					if (j_q == pk_q) begin
						// Whole ring scanned: empty circumcircle clips now,
						// otherwise this is a plain ear kept as fallback.
						if (circ_q) begin
							state_q <= S_CLIP_W;
						end else begin
							if (!fb_found_q) begin
								fb_found_q <= 1'b1;
								fb_pos_q   <= cur_q;
							end
							state_q <= S_ADV;
						end
					end else begin
						state_q <= S_SCAN_P;
					end
				end
				S_SCAN_P: begin
					vp_q <= ring_rd_q;
					if (circ_q) begin
						mode_q  <= M_ABC;
						cmd_q   <= '{start: 1'b1, entry: ect_pkg::PC_INCIRCLE};
						state_q <= S_CIRC;
					end else begin
						mode_q  <= M_T1;
						it_q    <= 2'd0;
						cmd_q   <= '{start: 1'b1, entry: ect_pkg::PC_ORIENT};
						state_q <= S_TRI;
					end
				end
				S_CIRC: begin
					if (stat.done) begin
						if (!stat.neg) begin
							circ_q <= 1'b0;
							if (trad_q) begin
								state_q <= S_ADV;
							end else begin
								mode_q  <= M_T1;
								it_q    <= 2'd0;
								cmd_q   <= '{start: 1'b1, entry: ect_pkg::PC_ORIENT};
								state_q <= S_TRI;
							end
						end else if (!trad_q) begin
							mode_q  <= M_T1;
							it_q    <= 2'd0;
							cmd_q   <= '{start: 1'b1, entry: ect_pkg::PC_ORIENT};
							state_q <= S_TRI;
						end else begin
							j_q     <= ring_next(j_q, size_q);
							state_q <= S_SCAN;
						end
					end else begin
						cmd_q.start <= 1'b0;
					end
				end
				S_TRI: begin
					if (stat.done) begin
						case (it_q)
							2'd0: begin
								sg1_q  <= sgn;
								it_q   <= 2'd1;
								mode_q <= M_T2;
								cmd_q  <= '{start: 1'b1, entry: ect_pkg::PC_ORIENT};
							end
							2'd1: begin
								sg2_q  <= sgn;
								it_q   <= 2'd2;
								mode_q <= M_T3;
								cmd_q  <= '{start: 1'b1, entry: ect_pkg::PC_ORIENT};
							end
							default: begin
								// Equal orientations put p inside the triangle.
								if ((sgn == sg1_q) && (sgn == sg2_q)) begin
									state_q <= S_ADV;
								end else begin
									j_q     <= ring_next(j_q, size_q);
									state_q <= S_SCAN;
								end
							end
						endcase
					end else begin
						cmd_q.start <= 1'b0;
					end
				end
				S_ADV: begin
					cur_q <= ring_next(cur_q, size_q);
					if (ring_next(cur_q, size_q) == lap_q) begin
						if (!fb_found_q) begin
							out_a_q     <= '0;
							out_b_q     <= '0;
							out_c_q     <= '0;
							out_st_q    <= ect_pkg::STATUS_FAILED;
							out_eor_q   <= 1'b1;
							out_valid_q <= 1'b1;
							state_q     <= S_LOAD;
						end else begin
							kk_q      <= fb_pos_q;
							rd_clip_q <= 1'b1;
							state_q   <= S_RD0;
						end
					end else begin
						state_q <= S_TOP;
					end
				end
				S_CLIP_W: begin
					tri_cnt_q <= tri_cnt_q + 1'b1;
					if (last_tri_q) begin
						e_idx_q <= '0;
						state_q <= S_EMIT_RD;
					end else if (CW'(kk_q) == size_q - 1'b1) begin
						state_q <= S_CLIP_END;
					end else begin
						j_q     <= kk_q;
						state_q <= S_MV_RD;
					end
				end
				S_MV_RD: state_q <= S_MV_WR;
				S_MV_WR: begin
					j_q <= j_q + 1'b1;
					if (CW'(j_q) == size_q - CW'(2)) begin
						state_q <= S_CLIP_END;
					end else begin
						state_q <= S_MV_RD;
					end
				end
				S_CLIP_END: begin
					size_q     <= size_q - 1'b1;
					fb_found_q <= 1'b0;
					if (CW'(kk_q) >= size_q - 1'b1) begin
						cur_q <= '0;
						lap_q <= '0;
					end else begin
						cur_q <= kk_q;
						lap_q <= kk_q;
					end
					state_q <= S_TOP;
				end
				S_EMIT_RD: state_q <= S_EMIT_CAP;
				S_EMIT_CAP: begin
					out_a_q     <= base_q + 32'(tmem_rd_q[3*PW-1:2*PW]);
					out_b_q     <= base_q + 32'(tmem_rd_q[2*PW-1:PW]);
					out_c_q     <= base_q + 32'(tmem_rd_q[PW-1:0]);
					out_st_q    <= ect_pkg::STATUS_TRI;
					out_eor_q   <= (e_idx_q == tri_cnt_q - 1'b1);
					out_valid_q <= 1'b1;
					state_q     <= S_EMIT_WAIT;
				end
				S_EMIT_WAIT: begin
					if (out_acc) begin
						if (e_idx_q == tri_cnt_q - 1'b1) begin
							state_q <= S_LOAD;
						end else begin
							e_idx_q <= e_idx_q + 1'b1;
							state_q <= S_EMIT_RD;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end
endmodule

// ===== test/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NV = ect_pkg::MAX_VERTS_DEF;
	// Longest wait with no transfer at all: the largest polygon used here
	// takes well under this to triangulate.
	localparam int STALL_LIMIT = 4000000;
	localparam int HOLD_CYCLES = 3000;
	localparam logic signed [31:0] CMIN = 32'sh8000_0000;
	localparam logic signed [31:0] CMAX = 32'sh7fff_ffff;

	typedef logic signed [255:0] wide_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [1:0]  st;
		logic        eor;
	} tri_res_t;

	// One row of the directed table. When fixed is set the single result is
	// typed in; otherwise the predictor decides.
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [31:0]        base;
		logic               last;
		logic               fixed;
		logic [1:0]         st;
	} vtx_row_t;

	localparam int NROWS = 22;
	localparam vtx_row_t DIRECTED [NROWS] = '{
		// A lone vertex: nothing to triangulate.
		'{32'sd0, 32'sd0, 32'd5, 1'b1, 1'b1, ect_pkg::STATUS_EMPTY},
		// Two vertices at the coordinate extremes.
		'{CMIN, CMAX, 32'd0, 1'b0, 1'b1, ect_pkg::STATUS_EMPTY},
		'{CMAX, CMIN, 32'd9, 1'b1, 1'b1, ect_pkg::STATUS_EMPTY},
		// Largest triangle, base wraps past the top of the index range.
		'{CMIN, CMIN, 32'hffff_ffff, 1'b0, 1'b0, ect_pkg::STATUS_TRI},
		'{CMAX, CMIN, 32'd0, 1'b0, 1'b0, ect_pkg::STATUS_TRI},
		'{32'sd0, CMAX, 32'd0, 1'b1, 1'b0, ect_pkg::STATUS_TRI},
		// Largest square, counterclockwise.
		'{CMIN, CMIN, 32'd0, 1'b0, 1'b0, ect_pkg::STATUS_TRI},
		'{CMAX, CMIN, 32'd1, 1'b0, 1'b0, ect_pkg::STATUS_TRI},
		'{CMAX, CMAX, 32'd2, 1'b0, 1'b0, ect_pkg::STATUS_TRI},
		'{CMIN, CMAX, 32'd3, 1'b1, 1'b0, ect_pkg::STATUS_TRI},
		// Clockwise square: no vertex is convex, so the polygon fails.
		'{32'sd0, 32'sd0, 32'd100, 1'b0, 1'b1, ect_pkg::STATUS_FAILED},
		'{32'sd0, 32'sd65536, 32'd0, 1'b0, 1'b1, ect_pkg::STATUS_FAILED},
		'{32'sd65536, 32'sd65536, 32'd0, 1'b0, 1'b1, ect_pkg::STATUS_FAILED},
		'{32'sd65536, 32'sd0, 32'd0, 1'b1, 1'b1, ect_pkg::STATUS_FAILED},
		// Three collinear points still come out as one triangle.
		'{32'sd0, 32'sd0, 32'd7, 1'b0, 1'b0, ect_pkg::STATUS_TRI},
		'{32'sd65536, 32'sd65536, 32'd0, 1'b0, 1'b0, ect_pkg::STATUS_TRI},
		'{32'sd131072, 32'sd131072, 32'd0, 1'b1, 1'b0, ect_pkg::STATUS_TRI},
		// Pentagon with one reflex vertex.
		'{32'sd0, 32'sd0, 32'd40, 1'b0, 1'b0, ect_pkg::STATUS_TRI},
		'{32'sd4, 32'sd0, 32'd0, 1'b0, 1'b0, ect_pkg::STATUS_TRI},
		'{32'sd4, 32'sd4, 32'd0, 1'b0, 1'b0, ect_pkg::STATUS_TRI},
		'{32'sd2, 32'sd1, 32'd0, 1'b0, 1'b0, ect_pkg::STATUS_TRI},
		'{32'sd0, 32'sd4, 32'd0, 1'b1, 1'b0, ect_pkg::STATUS_TRI}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ect_vtx_if verts_if();
	ect_tri_if tris_if();

	ear_clip_triangulator dut (
		.clk   (clk),
		.arst_n(arst_n),
		.verts (verts_if.sink),
		.tris  (tris_if.source)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Triangles the block still owes, oldest first.
	tri_res_t due_tris[$];
	int errors = 0;

	// Idle percentages for the two sides, set per phase by the main process.
	int tx_idle = 0;
	int rx_idle = 0;
	bit hold_req = 1'b0;

	// Predictor state: coordinates by position, the active ring, and the
	// triangles clipped so far for the polygon being solved.
	wide_t px[NV];
	wide_t py[NV];
	int loaded = 0;
	logic [31:0] poly_base = '0;
	int ring[$];
	int cur, lap, fb_pos;
	bit fb_found;
	int cut_a[$], cut_b[$], cut_c[$];

	function automatic int orient3(input int p, input int q, input int r);
		wide_t d;
		d = (px[q] - px[p]) * (py[r] - py[p]) - (py[q] - py[p]) * (px[r] - px[p]);
		return (d < 0) ? -1 : ((d == 0) ? 0 : 1);
	endfunction

	// True when d lies inside or on the circle through a, b, c.
	function automatic bit in_circ(input int a, input int b, input int c, input int d);
		wide_t ax, ay, bx, by, cx, cy, al, bl, cl, det;
		ax = px[a] - px[d];
		ay = py[a] - py[d];
		bx = px[b] - px[d];
		by = py[b] - py[d];
		cx = px[c] - px[d];
		cy = py[c] - py[d];
		al = ax * ax + ay * ay;
		bl = bx * bx + by * by;
		cl = cx * cx + cy * cy;
		det = ax * (by * cl - cy * bl) - ay * (bx * cl - cx * bl) + al * (bx * cy - cx * by);
		return det >= 0;
	endfunction

	// Inside only when all three orientations agree, all zero included.
	function automatic bit in_tri(input int p, input int a, input int b, input int c);
		int t1, t2, t3;
		t1 = orient3(p, a, b);
		t2 = orient3(p, b, c);
		t3 = orient3(p, c, a);
		return (t1 == t2) && (t2 == t3);
	endfunction

	function automatic int rprev(input int k);
		return (k == 0) ? ring.size() - 1 : k - 1;
	endfunction

	function automatic int rnext(input int k);
		return (k + 1 >= ring.size()) ? 0 : k + 1;
	endfunction

	// Circumcircle ear test at ring slot k. On entry plain_done says a plain
	// ear is already known this lap; on exit it is set when k is a plain ear or it was set on entry.
	function automatic bit ear_ok(input int k, inout bit plain_done);
		int pk, nk, a, b, c, j, p;
		bit circ;
		pk = rprev(k);
		nk = rnext(k);
		a = ring[pk];
		b = ring[k];
		c = ring[nk];
		j = rnext(nk);
		circ = 1'b1;
		while (j != pk) begin
			p = ring[j];
			if (circ && in_circ(a, b, c, p)) begin
				circ = 1'b0;
				if (plain_done)
					return 1'b0;
			end
			if (!plain_done && in_tri(p, a, b, c))
				return 1'b0;
			j = rnext(j);
		end
		plain_done = 1'b1;
		return circ;
	endfunction

	function automatic void clip_at(input int k);
		cut_a.insert(cut_a.size(), ring[rprev(k)]);
		cut_b.insert(cut_b.size(), ring[k]);
		cut_c.insert(cut_c.size(), ring[rnext(k)]);
		ring.delete(k);
		cur = (k >= ring.size()) ? 0 : k;
		lap = cur;
		fb_found = 1'b0;
	endfunction

	function automatic void triangulate(ref tri_res_t res[$], input int n);
		bit plain, clipped;
		int i;
		res.delete();
		if (n > NV) begin
			res.insert(res.size(),
				tri_res_t'{32'd0, 32'd0, 32'd0, ect_pkg::STATUS_OVERFLOW, 1'b1});
			return;
		end
		if (n < 3) begin
			res.insert(res.size(),
				tri_res_t'{32'd0, 32'd0, 32'd0, ect_pkg::STATUS_EMPTY, 1'b1});
			return;
		end
		ring.delete();
		cut_a.delete();
		cut_b.delete();
		cut_c.delete();
		for (i = 0; i < n; i++)
			ring.insert(ring.size(), i);
		cur = 0;
		lap = 0;
		fb_pos = 0;
		fb_found = 1'b0;
		while (ring.size() > 3) begin
			clipped = 1'b0;
			if (orient3(ring[rprev(cur)], ring[cur], ring[rnext(cur)]) > 0) begin
				plain = fb_found;
				if (ear_ok(cur, plain)) begin
					clip_at(cur);
					clipped = 1'b1;
				end else if (plain && !fb_found) begin
					fb_found = 1'b1;
					fb_pos = cur;
				end
			end
			if (!clipped) begin
				cur = rnext(cur);
				if (cur == lap) begin
					if (!fb_found) begin
						res.insert(res.size(),
							tri_res_t'{32'd0, 32'd0, 32'd0, ect_pkg::STATUS_FAILED, 1'b1});
						return;
					end
					clip_at(fb_pos);
				end
			end
		end
		cut_a.insert(cut_a.size(), ring[0]);
		cut_b.insert(cut_b.size(), ring[1]);
		cut_c.insert(cut_c.size(), ring[2]);
		for (i = 0; i < cut_a.size(); i++)
			res.insert(res.size(), tri_res_t'{poly_base + 32'(cut_a[i]),
				poly_base + 32'(cut_b[i]), poly_base + 32'(cut_c[i]),
				ect_pkg::STATUS_TRI, i == cut_a.size() - 1});
	endfunction

	// Account for one accepted vertex and return the triangles it releases.
	function automatic void absorb_vertex(ref tri_res_t res[$], input logic signed [31:0] x,
			input logic signed [31:0] y, input logic [31:0] b, input logic last);
		int n;
		res.delete();
		if (loaded == 0)
			poly_base = b;
		if (loaded < NV) begin
			px[loaded] = wide_t'(x);
			py[loaded] = wide_t'(y);
			loaded++;
		end else begin
			loaded = NV + 1;
		end
		if (last) begin
			n = loaded;
			loaded = 0;
			triangulate(res, n);
		end
	endfunction

	// Offer one vertex, idling first at the sender's rate, and wait for the
	// transfer. Valid stays high into the next call unless that call idles.
	task automatic send_vertex(input logic signed [31:0] x, input logic signed [31:0] y,
			input logic [31:0] b, input logic last, input logic fixed, input logic [1:0] st);
		tri_res_t res[$];
		while ($urandom_range(99) < tx_idle) begin
			verts_if.valid <= 1'b0;
			@(posedge clk);
		end
		verts_if.valid <= 1'b1;
		verts_if.vertex_x <= x;
		verts_if.vertex_y <= y;
		verts_if.index_base <= b;
		verts_if.last_vertex <= last;
		@(posedge clk);
		while (!verts_if.ready)
			@(posedge clk);
		absorb_vertex(res, x, y, b, last);
		if (fixed && last)
			due_tris.insert(due_tris.size(), tri_res_t'{32'd0, 32'd0, 32'd0, st, 1'b1});
		else
			foreach (res[i])
				due_tris.insert(due_tris.size(), res[i]);
	endtask

	// Twelve points of a strictly convex outline, counterclockwise. Any subset
	// kept in order is again a convex counterclockwise polygon.
	localparam int SHAPE_X [12] = '{4, 3, 2, 0, -2, -3, -4, -3, -2, 0, 2, 3};
	localparam int SHAPE_Y [12] = '{0, 2, 3, 4, 3, 2, 0, -2, -3, -4, -3, -2};

	task automatic send_polygon(inout int sent, input bit overflow);
		int xs[$], ys[$];
		bit keep[12];
		int n, kind, s, ox, oy, rot, i, k, j;
		logic [31:0] b;
		kind = $urandom_range(99);
		if (overflow) begin
			for (i = 0; i < NV + 1; i++) begin
				xs.insert(xs.size(), $urandom);
				ys.insert(ys.size(), $urandom);
			end
		end else if (kind < 78) begin
			n = ($urandom_range(19) == 0) ? 10 : $urandom_range(3, 7);
			foreach (keep[i])
				keep[i] = 1'b1;
			for (i = 0; i < 12 - n; i++) begin
				do k = $urandom_range(11); while (!keep[k]);
				keep[k] = 1'b0;
			end
			s = $urandom_range(1, 1 << 22);
			ox = int'($urandom_range(0, 1 << 27)) - (1 << 26);
			oy = int'($urandom_range(0, 1 << 27)) - (1 << 26);
			rot = $urandom_range(11);
			for (i = 0; i < 12; i++) begin
				k = (i + rot) % 12;
				if (keep[k]) begin
					xs.insert(xs.size(), ox + SHAPE_X[k] * s);
					ys.insert(ys.size(), oy + SHAPE_Y[k] * s);
				end
			end
			// Pull one vertex around so some polygons get reflex corners.
			if ($urandom_range(2) == 0) begin
				j = $urandom_range(n - 1);
				xs[j] = xs[j] - s * int'($urandom_range(0, 6)) + 3 * s;
				ys[j] = ys[j] - s * int'($urandom_range(0, 6)) + 3 * s;
			end
			if ($urandom_range(9) == 0) begin
				xs.reverse();
				ys.reverse();
			end
		end else begin
			n = $urandom_range(1, 6);
			for (i = 0; i < n; i++) begin
				xs.insert(xs.size(), $urandom);
				ys.insert(ys.size(), $urandom);
			end
		end
		b = ($urandom_range(3) == 0) ? 32'hffff_fff0 + $urandom_range(15) : $urandom;
		for (i = 0; i < xs.size(); i++) begin
			send_vertex(xs[i], ys[i], (i == 0) ? b : $urandom, i == xs.size() - 1, 1'b0,
				ect_pkg::STATUS_TRI);
			sent++;
		end
	endtask

	// Receiver: idles at its own rate, and once holds ready low for a long
	// stretch so the block backs up and stops taking vertices.
	int hold_left = 0;
	bit hold_done = 1'b0;

	always @(posedge clk) begin
		if (!arst_n) begin
			tris_if.ready <= 1'b0;
		end else if (hold_left > 0) begin
			tris_if.ready <= 1'b0;
			hold_left--;
		end else if (hold_req && !hold_done) begin
			tris_if.ready <= 1'b0;
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end else begin
			tris_if.ready <= ($urandom_range(99) >= rx_idle);
		end
	end

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
			errors++;
		end
	endfunction

	// Result checker and watchdog. Values are sampled at the edge, before any
	// nonblocking update of that edge lands.
	int quiet = 0;

	always @(posedge clk) begin
		tri_res_t want;
		if (arst_n && tris_if.valid && tris_if.ready) begin
			if (due_tris.size() == 0) begin
				$display("%0t unexpected result: corners %h %h %h status %0d end %b", $time,
					tris_if.corner_a, tris_if.corner_b, tris_if.corner_c, tris_if.status,
					tris_if.end_of_run);
				errors++;
			end else begin
				want = due_tris.pop_front();
				check_field("corner_a", want.a, tris_if.corner_a);
				check_field("corner_b", want.b, tris_if.corner_b);
				check_field("corner_c", want.c, tris_if.corner_c);
				check_field("status", want.st, tris_if.status);
				check_field("end_of_run", want.eor, tris_if.end_of_run);
			end
		end
		if ((tris_if.valid && tris_if.ready) || (verts_if.valid && verts_if.ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= STALL_LIMIT) begin
			$display("%0t no transfer for %0d cycles", $time, STALL_LIMIT);
			$display("ear_clip_triangulator verification failed");
			$finish;
		end
	end

	initial begin
		int sent;
		bit ovf_done;
		bit ovf;
		verts_if.valid = 1'b0;
		verts_if.vertex_x = '0;
		verts_if.vertex_y = '0;
		verts_if.index_base = '0;
		verts_if.last_vertex = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Phase one: sender idles less than the receiver, with the long hold.
		tx_idle = 28;
		rx_idle = 46;
		hold_req = 1'b1;

		foreach (DIRECTED[i])
			send_vertex(DIRECTED[i].x, DIRECTED[i].y, DIRECTED[i].base, DIRECTED[i].last,
				DIRECTED[i].fixed, DIRECTED[i].st);

		sent = 0;
		ovf_done = 1'b0;
		while (sent < 118) begin
			if (sent >= 25 && sent < 50) begin
				tx_idle = 46;
				rx_idle = 28;
			end else if (sent >= 50) begin
				tx_idle = 0;
				rx_idle = 0;
			end
			ovf = !ovf_done && sent >= 55;
			send_polygon(sent, ovf);
			if (ovf)
				ovf_done = 1'b1;
		end
		verts_if.valid <= 1'b0;

		while (due_tris.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("ear_clip_triangulator verification clean");
		else
			$display("ear_clip_triangulator verification failed");
		$finish;
	end

endmodule
